[hw/rtl/itr_pkg.sv]
package itr_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;

  localparam int RADIX_W   = 6;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int OUT_TDATA_W = 8;
  localparam int ADDR_W    = $clog2(MAX_DIGITS);
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int DIV_CNT_W = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h57;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [RADIX_W-1:0] radix_clamp(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_W'(d) + CHAR_ZERO;
    end else begin
      c = CHAR_W'(d) + CHAR_ALPHA;
    end
    return c;
  endfunction

endpackage

[hw/rtl/itr_ram.sv]
module itr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/itr_div.sv]
module itr_div
  import itr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [RADIX_W-1:0]     remainder,
  output div_stat_t              stat
);

  logic                   busy_r;
  logic                   done_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [VALUE_WIDTH-1:0] quo_r;
  logic [VALUE_WIDTH-1:0] quo_nxt;
  logic [RADIX_W-1:0]     rem_r;
  logic [RADIX_W-1:0]     rem_nxt;
  logic [RADIX_W-1:0]     divisor_r;
  logic [RADIX_W:0]       trial;
  logic [RADIX_W:0]       diff;
  logic                   ge;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial   = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff    = trial - {1'b0, divisor_r};
    ge      = (trial >= {1'b0, divisor_r});
    rem_nxt = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    quo_nxt = {quo_r[VALUE_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(VALUE_WIDTH - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

endmodule

[hw/rtl/int_to_radix_text_core.sv]
// Converts one integer per input transfer into ASCII text, most significant first; the
// value is signed in radix ten and unsigned otherwise. Digits come from repeated division
// by the radix in a single divider, one restoring step per cycle, each remainder stored as
// a digit, then a sign step. Each digit character is emitted by read, load and transfer
// steps, a minus sign by transfer only; transfers wait for out_tready. One value at a time.
// Reset (rst_n low, synchronous) sets the radix to ten and idles the block.
module int_to_radix_text_core
  import itr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [RADIX_W-1:0]     cfg_wr_data,  // radix
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [VALUE_WIDTH-1:0] in_tdata,     // value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,    // character in bits 6:0, bit 7 zero
  output logic                   out_tlast
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SGN  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_LD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [RADIX_W-1:0]     radix_r;
  logic [RADIX_W-1:0]     radix_eff;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]       limit;
  logic                   neg_r, neg_nxt;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [RADIX_W-1:0]     div_rem;
  div_stat_t              div_stat;
  logic                   ram_we;
  logic                   ram_re;
  logic [CNT_W-1:0]       rd_idx;
  logic [DIGIT_W-1:0]     ram_rdata;

  assign radix_eff = radix_clamp(radix_r);
  assign neg_in    = (radix_eff == RADIX_DEC) && in_tdata[VALUE_WIDTH-1];
  assign mag_in    = neg_in ? (~in_tdata + VALUE_WIDTH'(1)) : in_tdata;
  assign limit     = neg_r ? CNT_W'(MAX_DIGITS - 1) : CNT_W'(MAX_DIGITS);
  assign rd_idx    = n_r - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    div_dividend  = div_quo;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          neg_nxt      = neg_in;
          n_nxt        = '0;
          div_start    = 1'b1;
          div_dividend = mag_in;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (n_r < limit) begin
            ram_we = 1'b1;
            n_nxt  = n_r + CNT_W'(1);
          end
          if (div_quo != '0) begin
            div_start = 1'b1;
          end else begin
            state_nxt = S_SGN;
          end
        end
      end
      S_SGN: begin
        if (neg_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = (n_r == '0);
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        n_nxt     = rd_idx;
        state_nxt = S_LD;
      end
      S_LD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = digit_char(ram_rdata);
        out_last_nxt  = (n_r == '0);
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_last_r ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= RADIX_RESET;
      n_r         <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        radix_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  itr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix_eff),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  itr_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (n_r[ADDR_W-1:0]),
    .wr_data (div_rem),
    .rd_en   (ram_re),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("Input ready while a character is pending.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_DIGITS))
    else $error("Digit count exceeds the store depth.");

  a_minus_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_char_r == CHAR_MINUS) |-> (radix_eff == RADIX_DEC) && neg_r)
    else $error("Minus sign emitted outside a negative decimal conversion.");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("Divider restarted while busy.");
`endif

endmodule
